### hdl/tuag_pkg.sv
package tuag_pkg;

    localparam int SizeW    = 11;
    localparam int StrideW  = 24;
    localparam int SrcW     = 36;
    localparam int DstW     = 40;
    localparam int ModeW    = 2;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;
    localparam int NumDims  = 4;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MODE,
        CFG_SIZE_A,
        CFG_SIZE_B,
        CFG_SIZE_C,
        CFG_SIZE_D,
        CFG_STRIDE_A,
        CFG_STRIDE_B,
        CFG_STRIDE_C
    } t_cfg_idx;

    typedef logic [1:0] t_slot;

    localparam t_slot SLOT_L = 2'd0;
    localparam t_slot SLOT_K = 2'd1;
    localparam t_slot SLOT_I = 2'd2;
    localparam t_slot SLOT_J = 2'd3;

    // entry 0 is the innermost loop
    typedef t_slot [NumDims-1:0] t_order;

    function automatic t_order loop_order(input logic [ModeW-1:0] mode);
        t_order ord;
        case (mode)
            2'd0: begin
                ord = {SLOT_K, SLOT_I, SLOT_J, SLOT_L};
            end
            2'd1: begin
                ord = {SLOT_L, SLOT_I, SLOT_J, SLOT_K};
            end
            2'd2: begin
                ord = {SLOT_L, SLOT_K, SLOT_J, SLOT_I};
            end
            2'd3: begin
                ord = {SLOT_L, SLOT_K, SLOT_I, SLOT_J};
            end
            default: begin
                ord = {SLOT_K, SLOT_I, SLOT_J, SLOT_L};
            end
        endcase
        return ord;
    endfunction

endpackage

### hdl/tuag_offset_pipe.sv
module tuag_offset_pipe #(
    parameter int CntW = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [CntW-1:0]              i_cnt_l,
    input  logic [CntW-1:0]              i_cnt_k,
    input  logic [CntW-1:0]              i_cnt_i,
    input  logic [CntW-1:0]              i_cnt_j,
    input  logic [tuag_pkg::DstW-1:0]    i_dest,
    input  logic                         i_last,
    input  logic [tuag_pkg::StrideW-1:0] i_stride_a,
    input  logic [tuag_pkg::StrideW-1:0] i_stride_b,
    input  logic [tuag_pkg::StrideW-1:0] i_stride_c,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tuag_pkg::SrcW-1:0]    o_source_offset,
    output logic [tuag_pkg::DstW-1:0]    o_dest_index,
    output logic                         o_last
);
    import tuag_pkg::*;

    localparam int ProdW = CntW + StrideW;

    logic            r_v2;
    logic [SrcW-1:0] r_l2;
    logic [SrcW-1:0] r_pa2;
    logic [SrcW-1:0] r_pb2;
    logic [SrcW-1:0] r_pc2;
    logic [DstW-1:0] r_dest2;
    logic            r_last2;

    logic            r_v3;
    logic [SrcW-1:0] r_sum_lo3;
    logic [SrcW-1:0] r_sum_hi3;
    logic [DstW-1:0] r_dest3;
    logic            r_last3;

    logic            r_v4;
    logic [SrcW-1:0] r_src4;
    logic [DstW-1:0] r_dest4;
    logic            r_last4;

    logic             adv2;
    logic             adv3;
    logic             adv4;
    logic [ProdW-1:0] prod_a;
    logic [ProdW-1:0] prod_b;
    logic [ProdW-1:0] prod_c;

    assign adv4    = !r_v4 || i_ready;
    assign adv3    = !r_v3 || adv4;
    assign adv2    = !r_v2 || adv3;
    assign o_ready = adv2;

    assign prod_a = ProdW'(i_cnt_k) * ProdW'(i_stride_a);
    assign prod_b = ProdW'(i_cnt_i) * ProdW'(i_stride_b);
    assign prod_c = ProdW'(i_cnt_j) * ProdW'(i_stride_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv2) begin
                r_v2 <= i_valid;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv2 && i_valid) begin
            r_l2    <= SrcW'(i_cnt_l);
            r_pa2   <= SrcW'(prod_a);
            r_pb2   <= SrcW'(prod_b);
            r_pc2   <= SrcW'(prod_c);
            r_dest2 <= i_dest;
            r_last2 <= i_last;
        end
        if (adv3 && r_v2) begin
            r_sum_lo3 <= r_l2 + r_pa2;
            r_sum_hi3 <= r_pb2 + r_pc2;
            r_dest3   <= r_dest2;
            r_last3   <= r_last2;
        end
        if (adv4 && r_v3) begin
            r_src4  <= r_sum_lo3 + r_sum_hi3;
            r_dest4 <= r_dest3;
            r_last4 <= r_last3;
        end
    end

    assign o_valid         = r_v4;
    assign o_source_offset = r_src4;
    assign o_dest_index    = r_dest4;
    assign o_last          = r_last4;

endmodule

### hdl/tensor_unfold_address_generator_unit.sv
// Gather address generator for unfolding a strided 4D tensor into a matrix.
// Configuration: a write port (i_cfg_we, i_cfg_index, i_cfg_data) sets the
// loop order, the four extents and the three strides; write only while idle.
// Input channel (i_valid / o_ready, field i_restart): each accepted word is
// one tick of the walk. With i_restart high the counters restart, so that
// tick yields the first element of the unfolding.
// Output channel (o_valid / i_ready): one word per accepted input word, with
// the source offset, the destination index and a last flag. After the last
// element the counters wrap to zero on their own.
// Throughput: one word per cycle while the receiver accepts. Each word is
// registered in the counter stage, and the offset multiply and sum then run
// in a three-stage pipeline behind it before the word is valid on the output.
// When the receiver stalls, the pipeline fills its empty stages and then
// drops o_ready; nothing is lost or repeated.
// Reset: synchronous, active low. Counters and destination index go to zero,
// extents to 1, mode and strides to 0, and all pipeline stages empty.
module tensor_unfold_address_generator_unit #(
    parameter int DIM_MAX = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tuag_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [tuag_pkg::CfgDataW-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_restart,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [tuag_pkg::SrcW-1:0]     o_source_offset,
    output logic [tuag_pkg::DstW-1:0]     o_dest_index,
    output logic                          o_last
);
    import tuag_pkg::*;

    localparam int CntW = $clog2(DIM_MAX);
    localparam int ExtW = (CntW + 1 > SizeW) ? CntW + 1 : SizeW;

    logic [ModeW-1:0]   r_mode;
    logic [SizeW-1:0]   r_size   [NumDims];
    logic [StrideW-1:0] r_stride_a;
    logic [StrideW-1:0] r_stride_b;
    logic [StrideW-1:0] r_stride_c;

    logic [CntW-1:0] r_cnt [NumDims];
    logic [DstW-1:0] r_dest;

    logic            r_v1;
    logic [CntW-1:0] r_s1_cnt [NumDims];
    logic [DstW-1:0] r_s1_dest;
    logic            r_s1_last;

    logic            pipe_ready;
    logic            adv1;
    logic            accept;
    logic [CntW-1:0] cur      [NumDims];
    logic [CntW-1:0] n_cnt    [NumDims];
    logic [ExtW-1:0] ext      [NumDims];
    logic [NumDims-1:0] fin;
    logic [DstW-1:0] cur_dest;
    logic [DstW-1:0] n_dest;
    logic            cur_last;
    t_order          ord;

    assign adv1    = !r_v1 || pipe_ready;
    assign o_ready = adv1;
    assign accept  = i_valid && adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= '0;
            r_stride_a <= '0;
            r_stride_b <= '0;
            r_stride_c <= '0;
            for (int s = 0; s < NumDims; s++) begin
                r_size[s] <= SizeW'(1);
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE: begin
                    r_mode <= i_cfg_data[ModeW-1:0];
                end
                CFG_SIZE_A: begin
                    r_size[SLOT_L] <= i_cfg_data[SizeW-1:0];
                end
                CFG_SIZE_B: begin
                    r_size[SLOT_K] <= i_cfg_data[SizeW-1:0];
                end
                CFG_SIZE_C: begin
                    r_size[SLOT_I] <= i_cfg_data[SizeW-1:0];
                end
                CFG_SIZE_D: begin
                    r_size[SLOT_J] <= i_cfg_data[SizeW-1:0];
                end
                CFG_STRIDE_A: begin
                    r_stride_a <= i_cfg_data[StrideW-1:0];
                end
                CFG_STRIDE_B: begin
                    r_stride_b <= i_cfg_data[StrideW-1:0];
                end
                CFG_STRIDE_C: begin
                    r_stride_c <= i_cfg_data[StrideW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // extents clamped to 1..DIM_MAX; a counter at or past its extent minus one is final
    always_comb begin
        logic carry;
        carry = 1'b1;
        ord   = loop_order(r_mode);
        for (int s = 0; s < NumDims; s++) begin
            cur[s] = i_restart ? '0 : r_cnt[s];
            if (r_size[s] == '0) begin
                ext[s] = ExtW'(1);
            end else if (ExtW'(r_size[s]) > ExtW'(DIM_MAX)) begin
                ext[s] = ExtW'(DIM_MAX);
            end else begin
                ext[s] = ExtW'(r_size[s]);
            end
            fin[s]   = (ExtW'(cur[s]) + ExtW'(1)) >= ext[s];
            n_cnt[s] = cur[s];
        end
        for (int n = 0; n < NumDims; n++) begin
            if (carry) begin
                if (fin[ord[n]]) begin
                    n_cnt[ord[n]] = '0;
                end else begin
                    n_cnt[ord[n]] = cur[ord[n]] + CntW'(1);
                    carry         = 1'b0;
                end
            end
        end
        cur_dest = i_restart ? '0 : r_dest;
        cur_last = &fin;
        n_dest   = cur_last ? '0 : cur_dest + DstW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dest <= '0;
            r_v1   <= 1'b0;
            for (int s = 0; s < NumDims; s++) begin
                r_cnt[s] <= '0;
            end
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (accept) begin
                r_dest <= n_dest;
                for (int s = 0; s < NumDims; s++) begin
                    r_cnt[s] <= n_cnt[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_dest <= cur_dest;
            r_s1_last <= cur_last;
            for (int s = 0; s < NumDims; s++) begin
                r_s1_cnt[s] <= cur[s];
            end
        end
    end

    tuag_offset_pipe #(
        .CntW (CntW)
    ) u_offset_pipe (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (r_v1),
        .o_ready         (pipe_ready),
        .i_cnt_l         (r_s1_cnt[SLOT_L]),
        .i_cnt_k         (r_s1_cnt[SLOT_K]),
        .i_cnt_i         (r_s1_cnt[SLOT_I]),
        .i_cnt_j         (r_s1_cnt[SLOT_J]),
        .i_dest          (r_s1_dest),
        .i_last          (r_s1_last),
        .i_stride_a      (r_stride_a),
        .i_stride_b      (r_stride_b),
        .i_stride_c      (r_stride_c),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_source_offset (o_source_offset),
        .o_dest_index    (o_dest_index),
        .o_last          (o_last)
    );

endmodule

### test/tensor_unfold_address_generator_unit_tb.sv
module tensor_unfold_address_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tuag_pkg::*;

    localparam int DIM_MAX      = 1024;
    localparam int RANDOM_WORDS = 650;
    localparam int SETTLE       = 8;
    localparam int LIMIT        = 200_000;

    localparam logic [ModeW-1:0] MODE_KIJL = 2'd0;
    localparam logic [ModeW-1:0] MODE_LIJK = 2'd1;
    localparam logic [ModeW-1:0] MODE_LKJI = 2'd2;
    localparam logic [ModeW-1:0] MODE_LKIJ = 2'd3;

    typedef enum logic {ROW_WRITE, ROW_WORD} row_kind_e;

    typedef struct packed {
        logic [SrcW-1:0] src;
        logic [DstW-1:0] dst;
        logic            last;
    } addr_word_t;

    typedef struct packed {
        row_kind_e             kind;
        t_cfg_idx              idx;
        logic [CfgDataW-1:0]   data;
        logic                  restart;
        logic                  pinned;
        addr_word_t            exp;
    } plan_row_t;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CfgIdxW-1:0]   i_cfg_index = '0;
    logic [CfgDataW-1:0]  i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic                 i_restart   = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [SrcW-1:0]      o_source_offset;
    logic [DstW-1:0]      o_dest_index;
    logic                 o_last;

    // expectation forced by the directed table for the word on the bus
    logic                 pin_on   = 1'b0;
    addr_word_t           pin_word = '0;

    // shadow of the block
    logic [ModeW-1:0]     walk_mode;
    logic [SizeW-1:0]     size_reg [NumDims];
    logic [StrideW-1:0]   stride_k;
    logic [StrideW-1:0]   stride_i;
    logic [StrideW-1:0]   stride_j;
    logic [9:0]           walk_cnt [NumDims];
    logic [DstW-1:0]      walk_dest;
    addr_word_t           expected_addr_q [$];

    plan_row_t            plan [$];
    int                   send_idle_pct = 37;
    int                   stall_pct     = 62;
    int                   words_sent    = 0;
    int                   results_seen  = 0;
    int                   random_words  = 0;
    int                   wraps_seen    = 0;
    int                   restarts_seen = 0;
    int                   settings_used = 0;
    int                   bad_count     = 0;
    int                   cycle_cnt     = 0;

    tensor_unfold_address_generator_unit #(
        .DIM_MAX(DIM_MAX)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_restart      (i_restart),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_source_offset(o_source_offset),
        .o_dest_index   (o_dest_index),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("tensor_unfold_address_generator_unit: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic void shadow_write(input t_cfg_idx idx, input logic [CfgDataW-1:0] d);
        case (idx)
            CFG_MODE: walk_mode = d[ModeW-1:0];
            CFG_SIZE_A: size_reg[SLOT_L] = d[SizeW-1:0];
            CFG_SIZE_B: size_reg[SLOT_K] = d[SizeW-1:0];
            CFG_SIZE_C: size_reg[SLOT_I] = d[SizeW-1:0];
            CFG_SIZE_D: size_reg[SLOT_J] = d[SizeW-1:0];
            CFG_STRIDE_A: stride_k = d[StrideW-1:0];
            CFG_STRIDE_B: stride_i = d[StrideW-1:0];
            CFG_STRIDE_C: stride_j = d[StrideW-1:0];
            default: ;
        endcase
    endfunction

    function automatic addr_word_t advance_walk(input logic rs);
        addr_word_t               w;
        logic [SizeW-1:0]         ext [NumDims];
        logic [NumDims-1:0][1:0]  nest;
        logic [63:0]              sum;
        bit                       fin;
        bit                       carry;
        t_slot                    s;
        if (rs) begin
            for (int n = 0; n < NumDims; n++) walk_cnt[n] = '0;
            walk_dest = '0;
        end
        for (int n = 0; n < NumDims; n++) begin
            if (size_reg[n] == '0) begin
                ext[n] = 11'd1;
            end else if (size_reg[n] > SizeW'(DIM_MAX)) begin
                ext[n] = SizeW'(DIM_MAX);
            end else begin
                ext[n] = size_reg[n];
            end
        end
        sum = 64'(walk_cnt[SLOT_L])
            + 64'(walk_cnt[SLOT_K]) * 64'(stride_k)
            + 64'(walk_cnt[SLOT_I]) * 64'(stride_i)
            + 64'(walk_cnt[SLOT_J]) * 64'(stride_j);
        fin = 1'b1;
        for (int n = 0; n < NumDims; n++) begin
            if ({1'b0, walk_cnt[n]} + 11'd1 < ext[n]) fin = 1'b0;
        end
        w.src  = sum[SrcW-1:0];
        w.dst  = walk_dest;
        w.last = fin;
        // entry 0 is the innermost loop
        case (walk_mode)
            MODE_KIJL: nest = {SLOT_K, SLOT_I, SLOT_J, SLOT_L};
            MODE_LIJK: nest = {SLOT_L, SLOT_I, SLOT_J, SLOT_K};
            MODE_LKJI: nest = {SLOT_L, SLOT_K, SLOT_J, SLOT_I};
            default:   nest = {SLOT_L, SLOT_K, SLOT_I, SLOT_J};
        endcase
        carry = 1'b1;
        for (int n = 0; n < NumDims; n++) begin
            s = nest[n];
            if (carry) begin
                if ({1'b0, walk_cnt[s]} + 11'd1 >= ext[s]) begin
                    walk_cnt[s] = '0;
                end else begin
                    walk_cnt[s] = walk_cnt[s] + 10'd1;
                    carry = 1'b0;
                end
            end
        end
        if (fin) begin
            for (int n = 0; n < NumDims; n++) walk_cnt[n] = '0;
            walk_dest = '0;
        end else begin
            walk_dest = walk_dest + 1'b1;
        end
        return w;
    endfunction

    function automatic void report_bad(input string what, input addr_word_t want,
                                       input addr_word_t got);
        bad_count++;
        if (bad_count <= 10) begin
            $display("%0t %s: want src %h dst %h last %b, got src %h dst %h last %b",
                     $time, what, want.src, want.dst, want.last,
                     got.src, got.dst, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        addr_word_t want;
        addr_word_t got;
        if (!i_rst_n) begin
            walk_mode = MODE_KIJL;
            for (int n = 0; n < NumDims; n++) begin
                size_reg[n] = 11'd1;
                walk_cnt[n] = '0;
            end
            stride_k  = '0;
            stride_i  = '0;
            stride_j  = '0;
            walk_dest = '0;
            expected_addr_q.delete();
        end else begin
            if (i_cfg_we) shadow_write(t_cfg_idx'(i_cfg_index), i_cfg_data);
            if (i_valid && o_ready) begin
                if (i_restart) restarts_seen++;
                want = advance_walk(i_restart);
                if (pin_on) want = pin_word;
                expected_addr_q.push_back(want);
            end
            if (o_valid && i_ready) begin
                results_seen++;
                got.src  = o_source_offset;
                got.dst  = o_dest_index;
                got.last = o_last;
                if (got.last === 1'b1) wraps_seen++;
                if (expected_addr_q.size() == 0) begin
                    report_bad("unexpected word", '0, got);
                end else begin
                    want = expected_addr_q.pop_front();
                    if (got.src !== want.src || got.dst !== want.dst
                            || got.last !== want.last) begin
                        report_bad("wrong word", want, got);
                    end
                end
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgDataW-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
    endtask

    task automatic push_word(input logic rs, input logic pinned, input addr_word_t pw);
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= rs;
        pin_on    <= pinned;
        pin_word  <= pw;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic wait_idle();
        i_valid  <= 1'b0;
        i_cfg_we <= 1'b0;
        pin_on   <= 1'b0;
        while (results_seen < words_sent) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        settings_used++;
    endtask

    function automatic logic [CfgDataW-1:0] pick_data(input t_cfg_idx idx);
        logic [CfgDataW-1:0] noise;
        int unsigned         roll;
        noise = CfgDataW'($urandom);
        roll  = $urandom_range(19);
        case (idx)
            CFG_MODE: begin
                return noise;
            end
            CFG_STRIDE_A, CFG_STRIDE_B, CFG_STRIDE_C: begin
                if (roll < 3) return '0;
                if (roll < 6) return '1;
                if (roll < 9) return noise;
                return CfgDataW'($urandom_range(64));
            end
            default: begin
                if (roll == 0) return {noise[CfgDataW-1:SizeW], 11'd0};
                if (roll == 1) return {noise[CfgDataW-1:SizeW], 11'h7FF};
                if (roll == 2) return CfgDataW'(DIM_MAX);
                if (roll == 3) return {noise[CfgDataW-1:SizeW], 11'($urandom_range(2047))};
                return CfgDataW'($urandom_range(1, 3));
            end
        endcase
    endfunction

    task automatic random_phase(input bit write_all);
        int unsigned n_words;
        bit          well_formed;
        logic        rs;
        wait_idle();
        for (int r = 0; r <= int'(CFG_STRIDE_C); r++) begin
            if (write_all || $urandom_range(1) == 1) begin
                write_reg(t_cfg_idx'(r), pick_data(t_cfg_idx'(r)));
            end
        end
        well_formed = ($urandom_range(3) != 0);
        n_words = $urandom_range(16, 56);
        for (int w = 0; w < n_words; w++) begin
            if (w == 0) rs = well_formed;
            else rs = ($urandom_range(19) == 0);
            push_word(rs, 1'b0, '0);
            random_words++;
        end
    endtask

    function automatic plan_row_t cfg_row(input t_cfg_idx idx, input logic [CfgDataW-1:0] d);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_WRITE;
        row.idx  = idx;
        row.data = d;
        return row;
    endfunction

    function automatic plan_row_t word_row(input logic rs, input logic pinned,
                                           input logic [SrcW-1:0] src,
                                           input logic [DstW-1:0] dst, input logic last);
        plan_row_t row;
        row          = '0;
        row.kind     = ROW_WORD;
        row.restart  = rs;
        row.pinned   = pinned;
        row.exp.src  = src;
        row.exp.dst  = dst;
        row.exp.last = last;
        return row;
    endfunction

    initial begin
        plan_row_t row;
        bit        prev_write;
        // out of reset every extent is one
        plan.push_back(word_row(1'b0, 1'b1, 0, 0, 1'b1));
        plan.push_back(word_row(1'b1, 1'b1, 0, 0, 1'b1));
        // oversize and zero extents, full strides
        plan.push_back(cfg_row(CFG_MODE, {22'h3FFFFF, MODE_LKIJ}));
        plan.push_back(cfg_row(CFG_SIZE_A, 24'hFFFFFF));
        plan.push_back(cfg_row(CFG_SIZE_B, 24'h000000));
        plan.push_back(cfg_row(CFG_SIZE_C, 24'h000000));
        plan.push_back(cfg_row(CFG_SIZE_D, 24'h000001));
        plan.push_back(cfg_row(CFG_STRIDE_A, 24'hFFFFFF));
        plan.push_back(cfg_row(CFG_STRIDE_B, 24'hFFFFFF));
        plan.push_back(cfg_row(CFG_STRIDE_C, 24'hFFFFFF));
        plan.push_back(cfg_row(CFG_MODE, {22'h3FFFFF, MODE_KIJL}));
        plan.push_back(word_row(1'b1, 1'b1, 0, 0, 1'b0));
        plan.push_back(word_row(1'b0, 1'b1, 1, 1, 1'b0));
        plan.push_back(word_row(1'b0, 1'b1, 2, 2, 1'b0));
        plan.push_back(word_row(1'b0, 1'b1, 3, 3, 1'b0));
        // extent lowered under a running counter
        plan.push_back(cfg_row(CFG_SIZE_A, 24'h000002));
        plan.push_back(word_row(1'b0, 1'b1, 4, 4, 1'b1));
        plan.push_back(word_row(1'b0, 1'b1, 0, 0, 1'b0));
        plan.push_back(word_row(1'b0, 1'b1, 1, 1, 1'b1));
        plan.push_back(word_row(1'b0, 1'b1, 0, 0, 1'b0));
        plan.push_back(cfg_row(CFG_SIZE_B, 24'h000003));
        repeat (4) plan.push_back(word_row(1'b0, 1'b0, 0, 0, 1'b0));
        // loop order changed mid walk
        plan.push_back(cfg_row(CFG_MODE, 24'(MODE_LKJI)));
        repeat (3) plan.push_back(word_row(1'b0, 1'b0, 0, 0, 1'b0));
        plan.push_back(cfg_row(CFG_SIZE_C, 24'h0007FF));
        plan.push_back(cfg_row(CFG_SIZE_D, 24'hFFF800));
        plan.push_back(word_row(1'b1, 1'b0, 0, 0, 1'b0));
        repeat (3) plan.push_back(word_row(1'b0, 1'b0, 0, 0, 1'b0));
        plan.push_back(cfg_row(CFG_MODE, 24'(MODE_LIJK)));
        plan.push_back(cfg_row(CFG_SIZE_D, 24'h000005));
        plan.push_back(word_row(1'b0, 1'b0, 0, 0, 1'b0));
        plan.push_back(word_row(1'b0, 1'b0, 0, 0, 1'b0));
        plan.push_back(word_row(1'b1, 1'b0, 0, 0, 1'b0));
        plan.push_back(word_row(1'b0, 1'b0, 0, 0, 1'b0));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prev_write = 1'b0;
        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_WRITE) begin
                if (!prev_write) wait_idle();
                write_reg(row.idx, row.data);
            end else begin
                push_word(row.restart, row.pinned, row.exp);
            end
            prev_write = (row.kind == ROW_WRITE);
        end

        while (random_words < RANDOM_WORDS) begin
            if (random_words < RANDOM_WORDS / 3) begin
                send_idle_pct = 37;
                stall_pct     = 62;
            end else if (random_words < 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 62;
                stall_pct     = 37;
            end else begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            random_phase(random_words == 0);
        end
        wait_idle();

        $display("ran %0d words under %0d register settings", words_sent, settings_used);
        $display("saw %0d completed walks and %0d restarts, %0d bad words",
                 wraps_seen, restarts_seen, bad_count);
        if (expected_addr_q.size() != 0) begin
            $display("%0d expected words never arrived", expected_addr_q.size());
        end
        if (bad_count == 0 && expected_addr_q.size() == 0) begin
            $display("tensor_unfold_address_generator_unit: match");
        end else begin
            $display("tensor_unfold_address_generator_unit: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/tuag_pkg.sv
hdl/tuag_offset_pipe.sv
hdl/tensor_unfold_address_generator_unit.sv
test/tensor_unfold_address_generator_unit_tb.sv
